// File: src/rpnc_pkg.sv
// Shared types and constants for the RPN stack calculator.
`timescale 1ns / 1ps

package rpnc_pkg;

    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 3;
    localparam int DEPTH_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int OUT_TDATA_W = 40;

    // Operation codes carried in the input tuser
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;

    // Result status codes carried in the output tuser
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic                capture;
        logic                push;
        logic                alu_write;
        logic                div_start;
        logic                div_write;
        logic                load_out;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              lt2;
        logic              top_zero;
        logic              div_done;
        logic              out_busy;
    } t_dp_stat;

endpackage

// File: src/rpnc_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module rpnc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rpnc_pkg::DATA_W-1:0] i_dividend,
    input  logic [rpnc_pkg::DATA_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [rpnc_pkg::DATA_W-1:0] o_quotient
);

    localparam int W   = rpnc_pkg::DATA_W;
    localparam int CNW = $clog2(W);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_quo;
    logic [W-1:0]   r_mb;
    logic           r_neg;

    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W:0]   rem_sh;
    logic [W:0]   diff;

    assign mag_a  = i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
    assign mag_b  = i_divisor[W-1]  ? (W'(0) - i_divisor)  : i_divisor;
    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = rem_sh - {1'b0, r_mb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNW'(W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= mag_a;
            r_mb  <= mag_b;
            r_neg <= i_dividend[W-1] ^ i_divisor[W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNW'(1);
            // restoring step: keep the difference when it did not go negative
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (W'(0) - r_quo) : r_quo;

endmodule

// File: src/rpnc_dpath.sv
// Datapath: stack memory with cached top entry, ALU, divider and output register.
`timescale 1ns / 1ps

module rpnc_dpath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rpnc_pkg::t_dp_cmd             i_cmd,
    output rpnc_pkg::t_dp_stat            o_stat,
    input  logic [rpnc_pkg::FUNC_W-1:0]   i_func,
    input  logic [rpnc_pkg::DATA_W-1:0]   i_number,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rpnc_pkg::DATA_W-1:0]   o_top_value,
    output logic [rpnc_pkg::DEPTH_W-1:0]  o_depth,
    output logic [rpnc_pkg::STATUS_W-1:0] o_status
);

    localparam int W  = rpnc_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Entries below the top; the top itself lives in r_top
    logic [W-1:0] r_mem [STACK_DEPTH];

    logic [rpnc_pkg::FUNC_W-1:0]   r_func;
    logic [W-1:0]                  r_num;
    logic [W-1:0]                  r_top;
    logic [W-1:0]                  r_rd;
    logic [CW-1:0]                 r_count;
    logic                          r_out_valid;
    logic [W-1:0]                  r_out_top;
    logic [rpnc_pkg::DEPTH_W-1:0]  r_out_depth;
    logic [rpnc_pkg::STATUS_W-1:0] r_out_status;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [W-1:0]  alu_res;
    logic          div_done;
    logic [W-1:0]  div_q;

    assign wr_addr = AW'(r_count - CW'(1));
    assign rd_addr = AW'(r_count - CW'(2));

    always_comb begin
        priority if (r_func == rpnc_pkg::FUNC_ADD) begin
            alu_res = r_rd + r_top;
        end else if (r_func == rpnc_pkg::FUNC_SUB) begin
            alu_res = r_rd - r_top;
        end else begin
            alu_res = r_rd * r_top;
        end
    end

    rpnc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rd),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_count != '0) begin
            r_mem[wr_addr] <= r_top;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_num  <= i_number;
        end
        if (i_cmd.push) begin
            r_top <= r_num;
        end else if (i_cmd.alu_write) begin
            r_top <= alu_res;
        end else if (i_cmd.div_write) begin
            r_top <= div_q;
        end
        if (i_cmd.load_out) begin
            r_out_top    <= (r_count != '0) ? r_top : '0;
            r_out_depth  <= rpnc_pkg::DEPTH_W'(r_count);
            r_out_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.alu_write || i_cmd.div_write) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.func     = r_func;
    assign o_stat.full     = (r_count == CW'(STACK_DEPTH));
    assign o_stat.lt2      = (r_count < CW'(2));
    assign o_stat.top_zero = (r_top == '0);
    assign o_stat.div_done = div_done;
    assign o_stat.out_busy = r_out_valid && !i_ready;

    assign o_valid     = r_out_valid;
    assign o_top_value = r_out_top;
    assign o_depth     = r_out_depth;
    assign o_status    = r_out_status;

endmodule

// File: src/rpnc_ctrl.sv
// Controller: sequences decode, execute, divide and result hand-off for one item.
`timescale 1ns / 1ps

module rpnc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output rpnc_pkg::t_dp_cmd  o_cmd,
    input  rpnc_pkg::t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_DIV,
        S_FINISH
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [rpnc_pkg::STATUS_W-1:0] r_status;
    logic [rpnc_pkg::STATUS_W-1:0] n_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state  = S_DECODE;
                    n_status = rpnc_pkg::ST_OK;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                priority if (i_stat.func == rpnc_pkg::FUNC_PUSH) begin
                    if (i_stat.full) begin
                        n_status = rpnc_pkg::ST_FULL;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_stat.func > rpnc_pkg::FUNC_DIV) begin
                    // unused code: leave the stack alone
                    n_status = rpnc_pkg::ST_OK;
                end else if (i_stat.lt2) begin
                    n_status = rpnc_pkg::ST_UNDER;
                end else if (i_stat.func == rpnc_pkg::FUNC_DIV && i_stat.top_zero) begin
                    n_status = rpnc_pkg::ST_DIVZ;
                end else begin
                    // second entry is read during this cycle
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.func == rpnc_pkg::FUNC_DIV) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.alu_write = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.div_write = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= rpnc_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: src/rpn_stack_calculator.sv
// Top level of the RPN stack calculator with stream input and output.
`timescale 1ns / 1ps

// Postfix calculator over a stack of STACK_DEPTH signed 32-bit entries. Each input transaction
// carries an operation in s_axis_tuser (push, add, subtract, multiply, divide) and a number in
// s_axis_tdata; each one yields exactly one output transaction with the new top value, the depth
// and a status (ok, underflow, full stack, divide by zero). Items are handled one at a time.
// Push, unused codes and every error case pass through decode and result load before the next
// transaction is accepted; add, subtract and multiply add an execute step after decode; divide
// adds an execute step that starts the restoring divider, which resolves one quotient bit a
// cycle, and a wait for it to finish. The result turns valid as s_axis_tready rises again.
// A result waiting on m_axis_tready stalls the input only once the following result is ready.
// Stack memory is not cleared after reset; the depth count is.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] number
    input  logic [2:0]  s_axis_tuser,   // [2:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] top_value, [36:32] depth, [39:37] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    rpnc_pkg::t_dp_cmd  cmd;
    rpnc_pkg::t_dp_stat stat;

    logic [rpnc_pkg::DATA_W-1:0]  out_top;
    logic [rpnc_pkg::DEPTH_W-1:0] out_depth;

    rpnc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    rpnc_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_func      (s_axis_tuser),
        .i_number    (s_axis_tdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_top_value (out_top),
        .o_depth     (out_depth),
        .o_status    (m_axis_tuser)
    );

    assign m_axis_tdata = {
        (rpnc_pkg::OUT_TDATA_W - rpnc_pkg::DATA_W - rpnc_pkg::DEPTH_W)'(0),
        out_depth,
        out_top
    };

endmodule

// File: src/rpnc_checker.sv
// Port-level checks on the calculator's result stream, bound to the top level.
`timescale 1ns / 1ps

module rpnc_checker #(
    parameter int STACK_DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    localparam logic [4:0] DEPTH_FULL = 5'(STACK_DEPTH);
    localparam logic       NARROW     = (STACK_DEPTH < 32);

    // a stalled result must not change under the consumer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && NARROW && m_axis_tdata[36:32] == 5'd0 |->
            m_axis_tdata[31:0] == 32'd0)
        else $error("empty stack reports a non-zero top");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && NARROW && m_axis_tuser == rpnc_pkg::ST_UNDER |->
            m_axis_tdata[36:32] < 5'd2)
        else $error("underflow reported with two or more entries");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == rpnc_pkg::ST_FULL |->
            m_axis_tdata[36:32] == DEPTH_FULL)
        else $error("full-stack status without a full stack");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && NARROW |->
            m_axis_tdata[36:32] <= DEPTH_FULL && m_axis_tdata[39:37] == 3'd0)
        else $error("depth beyond stack size or padding not zero");

endmodule

bind rpn_stack_calculator rpnc_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_rpnc_checker (.*);
